// ===== src/rgba_alpha_gray_pixel_op_defines.svh =====
// Assertion macros for the pixel operation block.
// Both macros expect clk_i in scope at the place of use; the first also needs rst_ni.
`ifndef RGBA_ALPHA_GRAY_PIXEL_OP_DEFINES_SVH
`define RGBA_ALPHA_GRAY_PIXEL_OP_DEFINES_SVH

`ifndef SYNTHESIS
// Checked only while out of reset.
`define RGBAAG_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("rgbaag: assertion failed");
// Checked on every edge, reset included.
`define RGBAAG_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("rgbaag: reset assertion failed");
`else
`define RGBAAG_ASSERT(lbl, prop)
`define RGBAAG_ASSERT_RST(lbl, prop)
`endif

`endif

// ===== src/rgbaag_pkg.sv =====
package rgbaag_pkg;

  // Operation codes of the mode register.
  typedef enum logic [1:0] {
    MODE_GRAY     = 2'd0,
    MODE_PREMUL   = 2'd1,
    MODE_UNPREMUL = 2'd2
  } mode_e;

  // Luma weights and rounding bias.
  localparam logic [9:0]  GRAY_WR   = 10'd299;
  localparam logic [9:0]  GRAY_WG   = 10'd587;
  localparam logic [9:0]  GRAY_WB   = 10'd114;
  localparam logic [17:0] GRAY_BIAS = 18'd500;

  // Division by 1000 as a multiply by ceil(2^28 / 1000); exact for sums below 2^18.
  localparam int unsigned GRAY_SHIFT = 28;
  localparam logic [18:0] GRAY_RECIP = 19'd268436;

  // Premultiply rounding bias, and division by 255 as a multiply by ceil(2^24 / 255),
  // exact for products up to 65152.
  localparam logic [15:0] PM_BIAS  = 16'd127;
  localparam int unsigned PM_SHIFT = 24;
  localparam logic [16:0] PM_RECIP = 17'd65794;

  localparam logic [7:0] FULL_SCALE = 8'd255;

  // Number of quotient bits resolved in the middle stage; the rest are done last.
  localparam int unsigned DIV_HI_BITS = 4;

  // Word after the first stage: products and sums.
  typedef struct packed {
    logic [17:0]      gray_sum;
    logic [2:0][15:0] pm_prod;
    logic [2:0][15:0] up_num;
    logic [2:0][7:0]  color;
    logic [7:0]       alpha;
    logic             last;
  } s1_t;

  // Word after the second stage: scaled values and a partial division.
  typedef struct packed {
    logic [7:0]                   gray;
    logic [2:0][7:0]              pm;
    logic [2:0][15:0]             up_rem;
    logic [2:0][DIV_HI_BITS-1:0]  up_qhi;
    logic [2:0]                   up_sat;
    logic [2:0][7:0]              color;
    logic [7:0]                   alpha;
    logic                         last;
  } s2_t;

endpackage

// ===== src/rgbaag_front.sv =====
module rgbaag_front
  import rgbaag_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic       valid_i,
  input  logic [7:0] red_i,
  input  logic [7:0] green_i,
  input  logic [7:0] blue_i,
  input  logic [7:0] alpha_i,
  input  logic       last_i,
  output logic       valid_o,
  output s1_t        data_o
);

  logic [2:0][7:0] color;
  s1_t             data_d;
  s1_t             data_q;
  logic            valid_q;

  assign color = {blue_i, green_i, red_i};

  // Weighted luma sum, the per-channel alpha product and the unpremultiply numerator.
  always_comb begin
    data_d.gray_sum = 18'(red_i) * 18'(GRAY_WR) + 18'(green_i) * 18'(GRAY_WG)
                    + 18'(blue_i) * 18'(GRAY_WB) + GRAY_BIAS;
    for (int c = 0; c < 3; c++) begin
      data_d.pm_prod[c] = 16'(color[c]) * 16'(alpha_i) + PM_BIAS;
      data_d.up_num[c]  = 16'(color[c]) * 16'(FULL_SCALE) + 16'(alpha_i[7:1]);
    end
    data_d.color = color;
    data_d.alpha = alpha_i;
    data_d.last  = last_i;
  end

  // Stage valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // Stage payload.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== src/rgbaag_mid.sv =====
module rgbaag_mid
  import rgbaag_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic valid_i,
  input  s1_t  data_i,
  output logic valid_o,
  output s2_t  data_o
);

  logic [36:0]      gray_prod;
  logic [2:0][32:0] pm_scaled;
  s2_t              data_d;
  s2_t              data_q;
  logic             valid_q;

  // Reciprocal multiply for the division by 1000.
  assign gray_prod = 37'(data_i.gray_sum) * 37'(GRAY_RECIP);

  // Scaled luma and premultiply values, saturation check and the upper quotient bits of the unpremultiply division.
  always_comb begin
    logic [15:0] rem;
    logic [15:0] dv;
    data_d.gray = gray_prod[GRAY_SHIFT +: 8];
    for (int c = 0; c < 3; c++) begin
      pm_scaled[c]     = 33'(data_i.pm_prod[c]) * 33'(PM_RECIP);
      data_d.pm[c]     = pm_scaled[c][PM_SHIFT +: 8];
      data_d.up_sat[c] = 17'(data_i.up_num[c]) >= {1'b0, data_i.alpha, 8'd0};
      rem = data_i.up_num[c];
      for (int i = 0; i < DIV_HI_BITS; i++) begin
        dv = 16'(data_i.alpha) << (7 - i);
        if (rem >= dv) begin
          rem = rem - dv;
          data_d.up_qhi[c][DIV_HI_BITS-1-i] = 1'b1;
        end else begin
          data_d.up_qhi[c][DIV_HI_BITS-1-i] = 1'b0;
        end
      end
      data_d.up_rem[c] = rem;
    end
    data_d.color = data_i.color;
    data_d.alpha = data_i.alpha;
    data_d.last  = data_i.last;
  end

  // Stage valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // Stage payload.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== src/rgbaag_back.sv =====
module rgbaag_back
  import rgbaag_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic       valid_i,
  input  s2_t        data_i,
  input  logic [1:0] mode_i,
  output logic       valid_o,
  output logic [7:0] red_o,
  output logic [7:0] green_o,
  output logic [7:0] blue_o,
  output logic [7:0] alpha_o,
  output logic       last_o,
  output logic [1:0] mode_o
);

  localparam int unsigned LoBits = 8 - DIV_HI_BITS;

  logic [2:0][LoBits-1:0] up_qlo;
  logic [2:0][7:0]        up_val;
  logic [2:0][7:0]        color_d;
  logic [2:0][7:0]        color_q;
  logic [7:0]             alpha_q;
  logic                   last_q;
  logic [1:0]             mode_q;
  logic                   valid_q;

  // Lower quotient bits of the unpremultiply division, then saturation.
  always_comb begin
    logic [15:0] rem;
    logic [15:0] dv;
    for (int c = 0; c < 3; c++) begin
      rem = data_i.up_rem[c];
      for (int i = 0; i < LoBits; i++) begin
        dv = 16'(data_i.alpha) << (LoBits - 1 - i);
        if (rem >= dv) begin
          rem = rem - dv;
          up_qlo[c][LoBits-1-i] = 1'b1;
        end else begin
          up_qlo[c][LoBits-1-i] = 1'b0;
        end
      end
      up_val[c] = data_i.up_sat[c] ? FULL_SCALE : {data_i.up_qhi[c], up_qlo[c]};
    end
  end

  // Result select by mode; unused codes and zero alpha in unpremultiply pass through.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      case (mode_i)
        MODE_GRAY:     color_d[c] = data_i.gray;
        MODE_PREMUL:   color_d[c] = data_i.pm[c];
        MODE_UNPREMUL: color_d[c] = (data_i.alpha != 8'd0) ? up_val[c] : data_i.color[c];
        default:       color_d[c] = data_i.color[c];
      endcase
    end
  end

  // Output valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // Output word register.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      color_q <= color_d;
      alpha_q <= data_i.alpha;
      last_q  <= data_i.last;
      mode_q  <= mode_i;
    end
  end

  assign valid_o = valid_q;
  assign red_o   = color_q[0];
  assign green_o = color_q[1];
  assign blue_o  = color_q[2];
  assign alpha_o = alpha_q;
  assign last_o  = last_q;
  assign mode_o  = mode_q;

endmodule

// ===== src/rgba_alpha_gray_pixel_op.sv =====
// Channel   | Direction | Handshake              | Word
// ----------+-----------+------------------------+---------------------------------------
// pixel in  | input     | in_valid_i / in_stall_o   | red/green/blue/alpha/last _in_i
// pixel out | output    | out_valid_o / out_stall_i | red/green/blue/alpha/last _out_o
// mode      | input     | pixel_mode_we_i           | pixel_mode_i
//
// One pixel per clock while the output is not stalled.
// The depth is set by the three register stages: products, reciprocal scaling with
// the upper half of the unpremultiply division, lower half of the division and select.
// Reset clears the stage valid bits and sets the mode to grayscale.
// Each stage advances while it is empty or the stage after it advances, so bubbles
// close up and input is taken while a finished word waits at the output if a stage is empty.
`include "rgba_alpha_gray_pixel_op_defines.svh"

module rgba_alpha_gray_pixel_op
  import rgbaag_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       pixel_mode_we_i,
  input  logic [1:0] pixel_mode_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] red_in_i,
  input  logic [7:0] green_in_i,
  input  logic [7:0] blue_in_i,
  input  logic [7:0] alpha_in_i,
  input  logic       last_in_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] red_out_o,
  output logic [7:0] green_out_o,
  output logic [7:0] blue_out_o,
  output logic [7:0] alpha_out_o,
  output logic       last_out_o
);

  logic [1:0] mode_q;
  logic [1:0] out_mode;
  logic       v1;
  logic       v2;
  logic       en1;
  logic       en2;
  logic       en3;
  s1_t        s1;
  s2_t        s2;

  // Mode register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_GRAY;
    end else if (pixel_mode_we_i) begin
      mode_q <= pixel_mode_i;
    end
  end

  // Per-stage advance, from the output backwards.
  assign en3        = !out_valid_o || !out_stall_i;
  assign en2        = !v2 || en3;
  assign en1        = !v1 || en2;
  assign in_stall_o = !en1;

  rgbaag_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en1),
    .valid_i (in_valid_i),
    .red_i   (red_in_i),
    .green_i (green_in_i),
    .blue_i  (blue_in_i),
    .alpha_i (alpha_in_i),
    .last_i  (last_in_i),
    .valid_o (v1),
    .data_o  (s1)
  );

  rgbaag_mid u_mid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en2),
    .valid_i (v1),
    .data_i  (s1),
    .valid_o (v2),
    .data_o  (s2)
  );

  rgbaag_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en3),
    .valid_i (v2),
    .data_i  (s2),
    .mode_i  (mode_q),
    .valid_o (out_valid_o),
    .red_o   (red_out_o),
    .green_o (green_out_o),
    .blue_o  (blue_out_o),
    .alpha_o (alpha_out_o),
    .last_o  (last_out_o),
    .mode_o  (out_mode)
  );

  // The pipeline is empty from the edge after reset is seen.
  `RGBAAG_ASSERT_RST(a_reset_empty, !rst_ni |=> !out_valid_o)
  // Input is held back only when a word waits at a stalled output.
  `RGBAAG_ASSERT(a_stall_source, in_stall_o |-> (out_valid_o && out_stall_i))
  // Grayscale writes one value to all three colors.
  `RGBAAG_ASSERT(a_gray_equal, (out_valid_o && out_mode == MODE_GRAY) |-> (red_out_o == green_out_o && green_out_o == blue_out_o))
  // A premultiplied color never exceeds its alpha.
  `RGBAAG_ASSERT(a_premul_bound, (out_valid_o && out_mode == MODE_PREMUL) |-> (red_out_o <= alpha_out_o && green_out_o <= alpha_out_o && blue_out_o <= alpha_out_o))

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import rgbaag_pkg::*;

  // Mode value with no operation behind it; such pixels pass unchanged.
  localparam logic [1:0] MODE_SPARE = 2'd3;

  // Luma weights, rounding biases and full scale for the predictor.
  localparam int unsigned LUMA_R = 299;
  localparam int unsigned LUMA_G = 587;
  localparam int unsigned LUMA_B = 114;
  localparam int unsigned LUMA_BIAS = 500;
  localparam int unsigned LUMA_DIV = 1000;
  localparam int unsigned SCALE_BIAS = 127;
  localparam int unsigned SCALE_FULL = 255;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned RANDOM_PER_PHASE = 100;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       last;
  } rgba_word_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       pixel_mode_we_i = 1'b0;
  logic [1:0] pixel_mode_i = MODE_GRAY;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] red_in_i = '0;
  logic [7:0] green_in_i = '0;
  logic [7:0] blue_in_i = '0;
  logic [7:0] alpha_in_i = '0;
  logic       last_in_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] red_out_o;
  logic [7:0] green_out_o;
  logic [7:0] blue_out_o;
  logic [7:0] alpha_out_o;
  logic       last_out_o;

  rgba_word_t source_pixels_q[$];
  rgba_word_t converted_q[$];
  rgba_word_t next_pixel;
  rgba_word_t got_word;
  rgba_word_t want_word;

  logic [1:0]  mode_shadow = MODE_GRAY;
  logic        in_fire = 1'b0;
  logic        no_idle = 1'b0;
  int unsigned send_gap = 0;
  int unsigned stall_gap = 0;
  int unsigned words_queued = 0;
  int unsigned words_done = 0;
  int unsigned mismatches = 0;
  int unsigned mode_writes = 0;
  int unsigned cycle_count = 0;
  int unsigned words_per_mode[4] = '{0, 0, 0, 0};

  rgba_alpha_gray_pixel_op uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .pixel_mode_we_i (pixel_mode_we_i),
    .pixel_mode_i    (pixel_mode_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .red_in_i        (red_in_i),
    .green_in_i      (green_in_i),
    .blue_in_i       (blue_in_i),
    .alpha_in_i      (alpha_in_i),
    .last_in_i       (last_in_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .red_out_o       (red_out_o),
    .green_out_o     (green_out_o),
    .blue_out_o      (blue_out_o),
    .alpha_out_o     (alpha_out_o),
    .last_out_o      (last_out_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Scale one color by alpha / 255 with rounding.
  function automatic logic [7:0] scale_by_alpha(logic [7:0] chan, logic [7:0] alpha);
    int unsigned prod;
    prod = chan * alpha + SCALE_BIAS;
    return 8'(prod / SCALE_FULL);
  endfunction

  // Undo the alpha scaling of one color; alpha must be nonzero. Saturates at 255.
  function automatic logic [7:0] restore_from_alpha(logic [7:0] chan, logic [7:0] alpha);
    int unsigned quot;
    quot = (chan * SCALE_FULL + (alpha >> 1)) / alpha;
    if (quot > SCALE_FULL) begin
      quot = SCALE_FULL;
    end
    return 8'(quot);
  endfunction

  // Converted pixel for one input pixel under the given mode.
  function automatic rgba_word_t convert_pixel(logic [1:0] mode, rgba_word_t px);
    rgba_word_t res;
    int unsigned luma;
    res = px;
    case (mode)
      MODE_GRAY: begin
        luma = (px.red * LUMA_R + px.green * LUMA_G + px.blue * LUMA_B + LUMA_BIAS) / LUMA_DIV;
        if (luma > SCALE_FULL) begin
          luma = SCALE_FULL;
        end
        res.red = 8'(luma);
        res.green = 8'(luma);
        res.blue = 8'(luma);
      end
      MODE_PREMUL: begin
        res.red = scale_by_alpha(px.red, px.alpha);
        res.green = scale_by_alpha(px.green, px.alpha);
        res.blue = scale_by_alpha(px.blue, px.alpha);
      end
      MODE_UNPREMUL: begin
        if (px.alpha != 0) begin
          res.red = restore_from_alpha(px.red, px.alpha);
          res.green = restore_from_alpha(px.green, px.alpha);
          res.blue = restore_from_alpha(px.blue, px.alpha);
        end
      end
      default: begin
        res = px;
      end
    endcase
    return res;
  endfunction

  // Random pixel; alpha leans toward zero, full and tiny values, and in unpremultiply
  // mode most pixels are proper premultiplied colors (no channel above alpha).
  function automatic rgba_word_t random_pixel(logic [1:0] mode);
    rgba_word_t px;
    int unsigned pick;
    pick = $urandom_range(0, 7);
    case (pick)
      0: px.alpha = 8'd0;
      1: px.alpha = 8'd255;
      2: px.alpha = 8'($urandom_range(1, 3));
      default: px.alpha = 8'($urandom_range(0, 255));
    endcase
    if (mode == MODE_UNPREMUL && $urandom_range(0, 3) != 0) begin
      px.red = 8'($urandom_range(0, px.alpha));
      px.green = 8'($urandom_range(0, px.alpha));
      px.blue = 8'($urandom_range(0, px.alpha));
    end else begin
      px.red = ($urandom_range(0, 5) == 0) ? 8'd255 : 8'($urandom_range(0, 255));
      px.green = ($urandom_range(0, 5) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
      px.blue = 8'($urandom_range(0, 255));
    end
    px.last = ($urandom_range(0, 15) == 0);
    return px;
  endfunction

  task automatic queue_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a,
                             logic last);
    rgba_word_t px;
    px.red = r;
    px.green = g;
    px.blue = b;
    px.alpha = a;
    px.last = last;
    source_pixels_q.push_back(px);
    words_queued++;
  endtask

  task automatic queue_random(logic [1:0] mode, int unsigned count);
    repeat (count) begin
      source_pixels_q.push_back(random_pixel(mode));
      words_queued++;
    end
  endtask

  // Every queued word has come out once the done count catches up.
  task automatic wait_drained();
    do begin
      @(posedge clk_i);
    end while (words_done != words_queued);
  endtask

  // Mode writes happen only with the pipeline empty.
  task automatic write_mode(logic [1:0] mode);
    wait_drained();
    @(negedge clk_i);
    pixel_mode_we_i <= 1'b1;
    pixel_mode_i <= mode;
    @(negedge clk_i);
    pixel_mode_we_i <= 1'b0;
    mode_writes++;
    @(posedge clk_i);
  endtask

  // Pixel driver: holds a word until it is taken, with random idle bursts.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_gap <= 0;
    end else if (!in_valid_i || in_fire) begin
      if (send_gap != 0) begin
        in_valid_i <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (!no_idle && $urandom_range(0, 9) == 0) begin
        in_valid_i <= 1'b0;
        send_gap <= $urandom_range(0, 12);
      end else if (source_pixels_q.size() != 0) begin
        next_pixel = source_pixels_q.pop_front();
        red_in_i <= next_pixel.red;
        green_in_i <= next_pixel.green;
        blue_in_i <= next_pixel.blue;
        alpha_in_i <= next_pixel.alpha;
        last_in_i <= next_pixel.last;
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Output back-pressure in random bursts.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_gap <= 0;
    end else if (stall_gap != 0) begin
      out_stall_i <= 1'b1;
      stall_gap <= stall_gap - 1;
    end else if (!no_idle && $urandom_range(0, 9) == 0) begin
      out_stall_i <= 1'b1;
      stall_gap <= $urandom_range(0, 12);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Monitor: predicts each word taken at the input and checks each word leaving.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_valid_i && !in_stall_o;
      if (pixel_mode_we_i) begin
        mode_shadow <= pixel_mode_i;
      end
      if (in_valid_i && !in_stall_o) begin
        next_pixel.red = red_in_i;
        next_pixel.green = green_in_i;
        next_pixel.blue = blue_in_i;
        next_pixel.alpha = alpha_in_i;
        next_pixel.last = last_in_i;
        converted_q.push_back(convert_pixel(mode_shadow, next_pixel));
        words_per_mode[mode_shadow]++;
      end
      if (out_valid_o && !out_stall_i) begin
        got_word.red = red_out_o;
        got_word.green = green_out_o;
        got_word.blue = blue_out_o;
        got_word.alpha = alpha_out_o;
        got_word.last = last_out_o;
        words_done <= words_done + 1;
        if (converted_q.size() == 0) begin
          if (mismatches < 10) begin
            $display("ERROR: unexpected word r=%0d g=%0d b=%0d a=%0d last=%0d",
                     got_word.red, got_word.green, got_word.blue, got_word.alpha,
                     got_word.last);
          end
          mismatches++;
        end else begin
          want_word = converted_q.pop_front();
          if (got_word !== want_word) begin
            if (mismatches < 10) begin
              $display("ERROR: expected r=%0d g=%0d b=%0d a=%0d last=%0d, got r=%0d g=%0d b=%0d a=%0d last=%0d",
                       want_word.red, want_word.green, want_word.blue, want_word.alpha,
                       want_word.last, got_word.red, got_word.green, got_word.blue,
                       got_word.alpha, got_word.last);
            end
            mismatches++;
          end
        end
      end
    end
  end

  // Hard stop in case the pipeline hangs.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d words outstanding.", cycle_count,
               words_queued - words_done);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Grayscale out of reset: black, white, each primary, both marker values.
    queue_pixel(8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
    queue_pixel(8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
    queue_pixel(8'd255, 8'd0, 8'd0, 8'd17, 1'b0);
    queue_pixel(8'd0, 8'd255, 8'd0, 8'd128, 1'b0);
    queue_pixel(8'd0, 8'd0, 8'd255, 8'd1, 1'b1);

    // Premultiply: alpha zero clears colors, full alpha keeps them.
    write_mode(MODE_PREMUL);
    queue_pixel(8'd255, 8'd200, 8'd1, 8'd0, 1'b0);
    queue_pixel(8'd255, 8'd128, 8'd0, 8'd255, 1'b0);
    queue_pixel(8'd255, 8'd255, 8'd255, 8'd1, 1'b1);
    queue_pixel(8'd128, 8'd127, 8'd129, 8'd128, 1'b0);
    queue_pixel(8'd1, 8'd2, 8'd254, 8'd254, 1'b0);

    // Unpremultiply: alpha zero passes through, colors above alpha saturate.
    write_mode(MODE_UNPREMUL);
    queue_pixel(8'd200, 8'd13, 8'd255, 8'd0, 1'b0);
    queue_pixel(8'd255, 8'd128, 8'd0, 8'd255, 1'b1);
    queue_pixel(8'd1, 8'd0, 8'd255, 8'd1, 1'b0);
    queue_pixel(8'd64, 8'd65, 8'd100, 8'd128, 1'b0);
    queue_pixel(8'd1, 8'd2, 8'd3, 8'd3, 1'b0);
    queue_pixel(8'd255, 8'd254, 8'd127, 8'd254, 1'b1);

    // The unused mode value leaves pixels untouched.
    write_mode(MODE_SPARE);
    queue_pixel(8'd12, 8'd34, 8'd56, 8'd0, 1'b0);
    queue_pixel(8'd255, 8'd0, 8'd170, 8'd85, 1'b1);

    write_mode(MODE_GRAY);
    queue_pixel(8'd100, 8'd150, 8'd200, 8'd99, 1'b0);
    queue_pixel(8'd1, 8'd1, 8'd1, 8'd200, 1'b0);

    // Random phases over every mode; the final one runs without idling.
    write_mode(MODE_PREMUL);
    queue_random(MODE_PREMUL, RANDOM_PER_PHASE);
    write_mode(MODE_UNPREMUL);
    queue_random(MODE_UNPREMUL, RANDOM_PER_PHASE);
    write_mode(MODE_GRAY);
    queue_random(MODE_GRAY, RANDOM_PER_PHASE);
    write_mode(MODE_UNPREMUL);
    queue_random(MODE_UNPREMUL, RANDOM_PER_PHASE);
    write_mode(MODE_PREMUL);
    queue_random(MODE_PREMUL, RANDOM_PER_PHASE);
    write_mode(MODE_SPARE);
    queue_random(MODE_SPARE, RANDOM_PER_PHASE / 2);
    write_mode(MODE_GRAY);
    queue_random(MODE_GRAY, RANDOM_PER_PHASE);
    write_mode(MODE_UNPREMUL);
    no_idle = 1'b1;
    queue_random(MODE_UNPREMUL, RANDOM_PER_PHASE);

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (converted_q.size() != 0) begin
      $display("ERROR: %0d expected words never arrived", converted_q.size());
      mismatches += converted_q.size();
    end

    $display("Checked %0d words across %0d mode writes: gray %0d, premultiply %0d,",
             words_done, mode_writes, words_per_mode[MODE_GRAY], words_per_mode[MODE_PREMUL]);
    $display("unpremultiply %0d, unused mode %0d; %0d mismatches.",
             words_per_mode[MODE_UNPREMUL], words_per_mode[MODE_SPARE], mismatches);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== rgba_alpha_gray_pixel_op.f =====
+incdir+src
src/rgbaag_pkg.sv
src/rgbaag_front.sv
src/rgbaag_mid.sv
src/rgbaag_back.sv
src/rgba_alpha_gray_pixel_op.sv
test/tb.sv
